@@ hdl/barometer_pressure_temp_compensation_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the barometer compensation block
// Shared concurrent assertion forms with clock, reset and message arguments.
// ---------------------------------------------------------------------------
`ifndef BAROMETER_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define BAROMETER_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

// same-cycle implication
`define BPC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst)) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define BPC_ASSERT_DELAY(label, clk, rst, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst)) (ante) |-> ##(n) (cons)) \
    else $error(msg);

`endif

@@ hdl/bpc_pkg.sv @@
// ---------------------------------------------------------------------------
// bpc_pkg
// Types, widths and calibration decode shared by the compensation pipeline.
// ---------------------------------------------------------------------------
package bpc_pkg;

  localparam int RawW      = 24;
  localparam int CfgW      = 64;
  localparam int CfgIdxW   = 2;
  localparam int TempCalW  = 40;
  localparam int SumW      = 112;
  localparam int PressFrac = 79;
  localparam int Latency   = 11;

  localparam logic [16:0] PcOffset = 17'd16384;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTempCal = 2'd0,
    CfgPressA  = 2'd1,
    CfgPressB  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [RawW-1:0] raw_pressure;
    logic [RawW-1:0] raw_temperature;
  } in_beat_t;

  typedef struct packed {
    logic [RawW-1:0] temperature;
    logic [RawW-1:0] pressure;
    logic            saturated;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [7:0]  t3;
    logic [16:0] p1;
    logic [16:0] p2;
    logic [7:0]  p3;
    logic [7:0]  p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [7:0]  p7;
    logic [7:0]  p8;
    logic [15:0] p9;
    logic [7:0]  p10;
    logic [7:0]  p11;
  } cal_t;

  typedef struct packed {
    logic            valid;
    logic [RawW-1:0] u;
    logic [RawW-1:0] t;
    logic            sat;
  } temp_beat_t;

  typedef struct packed {
    logic            valid;
    logic [RawW-1:0] u;
    logic [RawW-1:0] t;
    logic            sat;
    logic [40:0]     a1;
    logic [40:0]     b1;
    logic [55:0]     a2;
    logic [55:0]     b2;
    logic [56:0]     a3l;
    logic [55:0]     a3h;
    logic [56:0]     b3l;
    logic [55:0]     b3h;
    logic [59:0]     el;
    logic [59:0]     eh;
  } terms_beat_t;

  function automatic cal_t cal_decode(logic [TempCalW-1:0] tc, logic [CfgW-1:0] pa,
                                      logic [CfgW-1:0] pb);
    cal_t c;
    c.t1  = tc[15:0];
    c.t2  = tc[31:16];
    c.t3  = tc[39:32];
    c.p1  = {pa[15], pa[15:0]} - PcOffset;
    c.p2  = {pa[31], pa[31:16]} - PcOffset;
    c.p3  = pa[39:32];
    c.p4  = pa[47:40];
    c.p5  = pa[63:48];
    c.p6  = pb[15:0];
    c.p7  = pb[23:16];
    c.p8  = pb[31:24];
    c.p9  = pb[47:32];
    c.p10 = pb[55:48];
    c.p11 = pb[63:56];
    return c;
  endfunction

endpackage

@@ hdl/bpc_temp.sv @@
// ---------------------------------------------------------------------------
// bpc_temp
// Four-stage temperature quadratic with rounding and saturation.
// ---------------------------------------------------------------------------
module bpc_temp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  bpc_pkg::in_beat_t     in_i,
  input  bpc_pkg::cal_t         cal_i,
  output bpc_pkg::temp_beat_t   beat_o
);

  localparam int TempFrac = 32;
  localparam logic signed [60:0] TempHalf = 61'sd1 <<< (TempFrac - 1);

  logic [3:0] v_q, v_d;
  logic [bpc_pkg::RawW-1:0] u1_q, u2_q, u3_q, u4_q;

  logic signed [24:0] d_q, d_d;
  logic signed [41:0] m1_q, m1_d, m1b_q;
  logic signed [49:0] dd_full;
  logic [47:0]        dd_q, dd_d;
  logic signed [56:0] m2_q, m2_d;
  logic signed [60:0] num;
  logic [5:0]         hi;
  logic               ovf;
  logic [bpc_pkg::RawW-1:0] t_q, t_d;
  logic               sat_q, sat_d;

  assign v_d = {v_q[2:0], valid_i};

  always_comb begin
    d_d     = $signed({1'b0, in_i.raw_temperature}) - $signed({1'b0, cal_i.t1, 8'b0});
    m1_d    = d_q * $signed({1'b0, cal_i.t2});
    dd_full = d_q * d_q;
    dd_d    = dd_full[47:0];
    m2_d    = $signed({1'b0, dd_q}) * $signed(cal_i.t3);
    num     = (m1b_q <<< 18) + m2_q + TempHalf;
    hi      = num[60:55];
    ovf     = !((&hi) || !(|hi));
    sat_d   = ovf;
    if (!ovf) begin
      t_d = num[55:32];
    end else if (num[60]) begin
      t_d = {1'b1, {(bpc_pkg::RawW-1){1'b0}}};
    end else begin
      t_d = {1'b0, {(bpc_pkg::RawW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    u1_q  <= in_i.raw_pressure;
    m1_q  <= m1_d;
    dd_q  <= dd_d;
    u2_q  <= u1_q;
    m1b_q <= m1_q;
    m2_q  <= m2_d;
    u3_q  <= u2_q;
    t_q   <= t_d;
    sat_q <= sat_d;
    u4_q  <= u3_q;
  end

  assign beat_o.valid = v_q[3];
  assign beat_o.u     = u4_q;
  assign beat_o.t     = t_q;
  assign beat_o.sat   = sat_q;

endmodule

@@ hdl/bpc_press_terms.sv @@
// ---------------------------------------------------------------------------
// bpc_press_terms
// Two-stage product bank for the pressure polynomial terms.
// ---------------------------------------------------------------------------
module bpc_press_terms (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bpc_pkg::cal_t         cal_i,
  input  bpc_pkg::temp_beat_t   beat_i,
  output bpc_pkg::terms_beat_t  terms_o
);

  logic [1:0] v_q, v_d;

  logic signed [23:0] t_s;
  logic signed [24:0] u_s;
  logic signed [47:0] t2_full;
  logic [46:0]        t2_q, t2_d;
  logic [47:0]        u2_q, u2_d;
  logic signed [40:0] a1_q, a1_d, b1_q, b1_d;
  logic signed [31:0] p8t_q, p8t_d, p4t_q, p4t_d, p10t;
  logic signed [32:0] p11u;
  logic signed [34:0] e_q, e_d;
  logic [bpc_pkg::RawW-1:0] u1_q, t1_q;
  logic               sat1_q;

  bpc_pkg::terms_beat_t o_q, o_d;

  assign v_d = {v_q[0], beat_i.valid};

  always_comb begin
    t_s     = $signed(beat_i.t);
    u_s     = $signed({1'b0, beat_i.u});
    t2_full = t_s * t_s;
    t2_d    = t2_full[46:0];
    u2_d    = beat_i.u * beat_i.u;
    a1_d    = $signed({1'b0, cal_i.p6}) * t_s;
    b1_d    = $signed(cal_i.p2) * t_s;
    p8t_d   = $signed(cal_i.p8) * t_s;
    p4t_d   = $signed(cal_i.p4) * t_s;
    p10t    = $signed(cal_i.p10) * t_s;
    p11u    = $signed(cal_i.p11) * u_s;
    e_d     = ($signed(cal_i.p9) <<< 17) + (p10t <<< 1) + p11u;
  end

  always_comb begin
    o_d       = '0;
    o_d.valid = v_q[0];
    o_d.u     = u1_q;
    o_d.t     = t1_q;
    o_d.sat   = sat1_q;
    o_d.a1    = a1_q;
    o_d.b1    = b1_q;
    o_d.a2    = $signed(cal_i.p7) * $signed({1'b0, t2_q});
    o_d.b2    = $signed(cal_i.p3) * $signed({1'b0, t2_q});
    o_d.a3l   = p8t_q * $signed({1'b0, t2_q[23:0]});
    o_d.a3h   = p8t_q * $signed({1'b0, t2_q[46:24]});
    o_d.b3l   = p4t_q * $signed({1'b0, t2_q[23:0]});
    o_d.b3h   = p4t_q * $signed({1'b0, t2_q[46:24]});
    o_d.el    = e_q * $signed({1'b0, u2_q[23:0]});
    o_d.eh    = e_q * $signed({1'b0, u2_q[47:24]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t2_q   <= t2_d;
    u2_q   <= u2_d;
    a1_q   <= a1_d;
    b1_q   <= b1_d;
    p8t_q  <= p8t_d;
    p4t_q  <= p4t_d;
    e_q    <= e_d;
    u1_q   <= beat_i.u;
    t1_q   <= beat_i.t;
    sat1_q <= beat_i.sat;
    o_q    <= o_d;
  end

  always_comb begin
    terms_o       = o_q;
    terms_o.valid = v_q[1];
  end

endmodule

@@ hdl/bpc_press_sum.sv @@
// ---------------------------------------------------------------------------
// bpc_press_sum
// Five-stage wide accumulation of the pressure terms, rounding and clipping.
// ---------------------------------------------------------------------------
module bpc_press_sum (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bpc_pkg::cal_t         cal_i,
  input  bpc_pkg::terms_beat_t  terms_i,
  output logic                  valid_o,
  output bpc_pkg::out_beat_t    res_o
);

  localparam int W = bpc_pkg::SumW;
  localparam int LimbW = 28;
  localparam int PHi = bpc_pkg::PressFrac + bpc_pkg::RawW;
  localparam logic signed [W-1:0] PressHalf = {{(W-1){1'b0}}, 1'b1} <<< (bpc_pkg::PressFrac - 1);

  logic [4:0] v_q, v_d;
  logic [bpc_pkg::RawW-1:0] u3_q, u4_q;
  logic [bpc_pkg::RawW-1:0] t3_q, t4_q, t5_q, t6_q;
  logic sat3_q, sat4_q, sat5_q, sat6_q;

  logic signed [79:0] a3_q, a3_d, b3_q, b3_d;
  logic signed [83:0] aq_q, aq_d, bq_q, bq_d, e3_q, e3_d, e4_q;
  logic signed [84:0] a_q, a_d, b_q, b_d;
  logic signed [53:0] ub0_q, ub0_d, ub1_q, ub1_d, ub2_q, ub2_d;
  logic signed [24:0] u_s;
  logic signed [W-1:0] ae_q, ae_d, x_q, x_d, y_q, y_d, s;
  logic neg, over;
  bpc_pkg::out_beat_t res_q, res_d;

  assign v_d = {v_q[3:0], terms_i.valid};

  always_comb begin
    a3_d = ($signed(terms_i.a3h) <<< 24) + $signed(terms_i.a3l);
    b3_d = ($signed(terms_i.b3h) <<< 24) + $signed(terms_i.b3l);
    e3_d = ($signed(terms_i.eh) <<< 24) + $signed(terms_i.el);
    aq_d = ($signed({1'b0, cal_i.p5}) <<< 66) + ($signed(terms_i.a1) <<< 41)
         + ($signed(terms_i.a2) <<< 23);
    bq_d = ($signed(cal_i.p1) <<< 65) + ($signed(terms_i.b1) <<< 40)
         + ($signed(terms_i.b2) <<< 21);
    a_d  = a3_q + aq_q;
    b_d  = b3_q + bq_q;
    u_s   = $signed({1'b0, u4_q});
    ub0_d = $signed({1'b0, b_q[LimbW-1:0]}) * u_s;
    ub1_d = $signed({1'b0, b_q[2*LimbW-1:LimbW]}) * u_s;
    ub2_d = $signed(b_q[84:2*LimbW]) * u_s;
    ae_d  = (a_q <<< 22) + (e4_q <<< 20);
    x_d   = ub0_q + (ub1_q <<< LimbW);
    y_d   = ae_q + (ub2_q <<< (2 * LimbW)) + PressHalf;
    s     = x_q + y_q;
    neg   = s[W-1];
    over  = |s[W-2:PHi];
    res_d.temperature = t6_q;
    res_d.saturated   = sat6_q || neg || over;
    if (neg) begin
      res_d.pressure = '0;
    end else if (over) begin
      res_d.pressure = '1;
    end else begin
      res_d.pressure = s[PHi-1:bpc_pkg::PressFrac];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a3_q   <= a3_d;
    b3_q   <= b3_d;
    e3_q   <= e3_d;
    aq_q   <= aq_d;
    bq_q   <= bq_d;
    u3_q   <= terms_i.u;
    t3_q   <= terms_i.t;
    sat3_q <= terms_i.sat;
    a_q    <= a_d;
    b_q    <= b_d;
    e4_q   <= e3_q;
    u4_q   <= u3_q;
    t4_q   <= t3_q;
    sat4_q <= sat3_q;
    ub0_q  <= ub0_d;
    ub1_q  <= ub1_d;
    ub2_q  <= ub2_d;
    ae_q   <= ae_d;
    t5_q   <= t4_q;
    sat5_q <= sat4_q;
    x_q    <= x_d;
    y_q    <= y_d;
    t6_q   <= t5_q;
    sat6_q <= sat5_q;
    res_q  <= res_d;
  end

  assign valid_o = v_q[4];
  assign res_o   = res_q;

endmodule

@@ hdl/barometer_pressure_temp_compensation.sv @@
// ---------------------------------------------------------------------------
// barometer_pressure_temp_compensation
// Pipelined polynomial compensation of raw pressure and temperature samples.
// ---------------------------------------------------------------------------
// One sample is taken on every clock edge where start is high and busy is
// low; busy is high only in reset and until the first edge after release.
// Each result shows on res_o for exactly one cycle under result_valid_o, 11
// cycles after its sample was taken, and must be captured in that cycle since
// the receiver cannot stall the pipe. The 11 stages are four for the
// temperature quadratic, two for the pressure product bank, and five for the
// wide pressure sum, where the 85-bit raw-pressure coefficient is multiplied
// in three 28-bit limbs. Write calibration only while no sample is in flight.
module barometer_pressure_temp_compensation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bpc_pkg::in_beat_t             in_i,
  input  logic                          cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpc_pkg::CfgW-1:0]      cfg_wdata_i,
  output logic                          result_valid_o,
  output bpc_pkg::out_beat_t            res_o
);

  logic busy_q, busy_d;
  logic [bpc_pkg::TempCalW-1:0] temp_cal_q, temp_cal_d;
  logic [bpc_pkg::CfgW-1:0]     press_a_q, press_a_d, press_b_q, press_b_d;
  logic accept;
  bpc_pkg::cal_t        cal;
  bpc_pkg::temp_beat_t  temp_beat;
  bpc_pkg::terms_beat_t terms_beat;

  assign busy_d = 1'b0;
  assign accept = start && !busy_q;
  assign busy   = busy_q;

  always_comb begin
    temp_cal_d = temp_cal_q;
    press_a_d  = press_a_q;
    press_b_d  = press_b_q;
    if (cfg_we_i) begin
      unique case (bpc_pkg::cfg_idx_e'(cfg_idx_i))
        bpc_pkg::CfgTempCal: temp_cal_d = cfg_wdata_i[bpc_pkg::TempCalW-1:0];
        bpc_pkg::CfgPressA:  press_a_d  = cfg_wdata_i;
        bpc_pkg::CfgPressB:  press_b_d  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      temp_cal_q <= '0;
      press_a_q  <= '0;
      press_b_q  <= '0;
    end else begin
      busy_q     <= busy_d;
      temp_cal_q <= temp_cal_d;
      press_a_q  <= press_a_d;
      press_b_q  <= press_b_d;
    end
  end

  assign cal = bpc_pkg::cal_decode(temp_cal_q, press_a_q, press_b_q);

  bpc_temp u_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .in_i    (in_i),
    .cal_i   (cal),
    .beat_o  (temp_beat)
  );

  bpc_press_terms u_terms (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cal_i   (cal),
    .beat_i  (temp_beat),
    .terms_o (terms_beat)
  );

  bpc_press_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cal_i   (cal),
    .terms_i (terms_beat),
    .valid_o (result_valid_o),
    .res_o   (res_o)
  );

endmodule

@@ hdl/bpc_checker.sv @@
// ---------------------------------------------------------------------------
// bpc_checker
// Port-level timing and clipping checks, bound to the top level.
// ---------------------------------------------------------------------------
`include "barometer_pressure_temp_compensation_defines.svh"

module bpc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               result_valid_o,
  input bpc_pkg::out_beat_t res_o
);

  `BPC_ASSERT_DELAY(a_beat_returns, clk_i, rst_ni, start && !busy, bpc_pkg::Latency, result_valid_o, "accepted beat produced no result at the fixed latency")

  `BPC_ASSERT_IMPLY(a_no_stray_result, clk_i, rst_ni, result_valid_o, $past(start && !busy, bpc_pkg::Latency), "result strobe without an accepted beat")

  `BPC_ASSERT_IMPLY(a_sat_clipped, clk_i, rst_ni, result_valid_o && res_o.saturated, res_o.temperature == 24'h7FFFFF || res_o.temperature == 24'h800000 || res_o.pressure == 24'h000000 || res_o.pressure == 24'hFFFFFF, "saturated flag set on an unclipped result")

endmodule

bind barometer_pressure_temp_compensation bpc_checker u_bpc_checker (.*);

@@ tb/sv/tb_barometer_pressure_temp_compensation.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_barometer_pressure_temp_compensation
// Self-checking bench for the barometer compensation pipeline. A directed
// table covers reset defaults, ignored register writes and both saturation
// limits of each output. Random phases then follow under zero, all-ones,
// plausible and fully random calibration. Every sample taken is scored
// against a pinned table value or a bit-exact fixed-point polynomial model.
// ---------------------------------------------------------------------------
module tb_barometer_pressure_temp_compensation;
  import bpc_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;
  localparam int PhaseCount = 10;
  localparam int PhaseBeats = 90;

  typedef enum logic {RowWrite, RowBeat} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgW-1:0]     data;
    in_beat_t            beat;
    bit                  pinned;
    out_beat_t           gold;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  in_beat_t           sample;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_wdata;
  logic               result_valid;
  out_beat_t          result;

  bit                 pin_gold;
  out_beat_t          pin_value;

  logic [TempCalW-1:0] mirror_temp_cal = '0;
  logic [CfgW-1:0]     mirror_press_a  = '0;
  logic [CfgW-1:0]     mirror_press_b  = '0;

  out_beat_t expected_readings[$];
  int        errors    = 0;
  int        calm_left = 0;

  dir_row_t directed_rows [28] = '{
    '{RowBeat,  CfgTempCal, '0, {24'h000000, 24'h000000}, 1'b1, {24'h000000, 24'h000000, 1'b0}},
    '{RowBeat,  CfgTempCal, '0, {24'h000001, 24'h000000}, 1'b1, {24'h000000, 24'h000000, 1'b1}},
    '{RowBeat,  CfgTempCal, '0, {24'hFFFFFF, 24'hFFFFFF}, 1'b1, {24'h000000, 24'h000000, 1'b1}},
    '{RowBeat,  CfgTempCal, '0, {24'h000000, 24'hFFFFFF}, 1'b1, {24'h000000, 24'h000000, 1'b0}},
    '{RowWrite, CfgSpare, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0},
    '{RowBeat,  CfgTempCal, '0, {24'h000000, 24'hFFFFFF}, 1'b1, {24'h000000, 24'h000000, 1'b0}},
    '{RowBeat,  CfgTempCal, '0, {24'h000001, 24'h800000}, 1'b1, {24'h000000, 24'h000000, 1'b1}},
    '{RowWrite, CfgPressA, 64'hFFFF_0000_4000_4000, '0, 1'b0, '0},
    '{RowBeat,  CfgTempCal, '0, {24'h000000, 24'h000000}, 1'b1, {24'h000000, 24'hFFFFFF, 1'b1}},
    '{RowBeat,  CfgTempCal, '0, {24'hFFFFFF, 24'h000000}, 1'b1, {24'h000000, 24'hFFFFFF, 1'b1}},
    '{RowWrite, CfgTempCal, 64'h0000_007F_FFFF_0000, '0, 1'b0, '0},
    '{RowBeat,  CfgTempCal, '0, {24'h000000, 24'hFFFFFF}, 1'b1, {24'h7FFFFF, 24'hFFFFFF, 1'b1}},
    '{RowBeat,  CfgTempCal, '0, {24'h000000, 24'h000000}, 1'b1, {24'h000000, 24'hFFFFFF, 1'b1}},
    '{RowWrite, CfgTempCal, 64'hA5A5_A580_FFFF_FFFF, '0, 1'b0, '0},
    '{RowBeat,  CfgTempCal, '0, {24'h000000, 24'h000000}, 1'b1, {24'h800000, 24'hFFFFFF, 1'b1}},
    '{RowBeat,  CfgTempCal, '0, {24'hFFFFFF, 24'hFFFFFF}, 1'b0, '0},
    '{RowWrite, CfgPressA, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0},
    '{RowWrite, CfgPressB, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, '0},
    '{RowBeat,  CfgTempCal, '0, {24'hFFFFFF, 24'hFFFFFF}, 1'b0, '0},
    '{RowBeat,  CfgTempCal, '0, {24'h000000, 24'h000000}, 1'b0, '0},
    '{RowWrite, CfgTempCal, 64'h0000_00F9_6743_6B70, '0, 1'b0, '0},
    '{RowWrite, CfgPressA, 64'h6350_F523_1A2B_F3C8, '0, 1'b0, '0},
    '{RowWrite, CfgPressB, 64'hC41E_4213_FA0B_6A35, '0, 1'b0, '0},
    '{RowBeat,  CfgTempCal, '0, {24'h6ACFC0, 24'h6D0000}, 1'b0, '0},
    '{RowBeat,  CfgTempCal, '0, {24'h500000, 24'h6B7000}, 1'b0, '0},
    '{RowBeat,  CfgTempCal, '0, {24'hFFFFFF, 24'h000000}, 1'b0, '0},
    '{RowBeat,  CfgTempCal, '0, {24'h000000, 24'hFFFFFF}, 1'b0, '0},
    '{RowBeat,  CfgTempCal, '0, {24'h800000, 24'h800000}, 1'b0, '0}
  };

  barometer_pressure_temp_compensation dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (sample),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .result_valid_o (result_valid),
    .res_o          (result)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic out_beat_t compensate(in_beat_t smp);
    longint t1, t2, t3, dt, num, tq;
    logic signed [159:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    logic signed [159:0] wt, wu, acc;
    out_beat_t r;
    t1  = longint'(mirror_temp_cal[15:0]);
    t2  = longint'(mirror_temp_cal[31:16]);
    t3  = longint'($signed(mirror_temp_cal[39:32]));
    p1  = longint'($signed(mirror_press_a[15:0])) - 64'sd16384;
    p2  = longint'($signed(mirror_press_a[31:16])) - 64'sd16384;
    p3  = longint'($signed(mirror_press_a[39:32]));
    p4  = longint'($signed(mirror_press_a[47:40]));
    p5  = longint'(mirror_press_a[63:48]);
    p6  = longint'(mirror_press_b[15:0]);
    p7  = longint'($signed(mirror_press_b[23:16]));
    p8  = longint'($signed(mirror_press_b[31:24]));
    p9  = longint'($signed(mirror_press_b[47:32]));
    p10 = longint'($signed(mirror_press_b[55:48]));
    p11 = longint'($signed(mirror_press_b[63:56]));

    dt  = longint'(smp.raw_temperature) - 256 * t1;
    num = dt * t2 * 262144 + dt * dt * t3 + (longint'(1) <<< 31);
    tq  = num >>> 32;
    r.saturated = 1'b0;
    if (tq > 8388607) begin
      tq = 8388607;
      r.saturated = 1'b1;
    end
    if (tq < -8388608) begin
      tq = -8388608;
      r.saturated = 1'b1;
    end
    r.temperature = tq[23:0];

    wt  = tq;
    wu  = longint'(smp.raw_pressure);
    acc = (p5 <<< 88) + ((p6 * wt) <<< 63) + ((p7 * wt * wt) <<< 45)
        + ((p8 * wt * wt * wt) <<< 22) + ((p1 * wu) <<< 65) + ((p2 * wu * wt) <<< 40)
        + ((p3 * wt * wt * wu) <<< 21) + (p4 * wt * wt * wt * wu)
        + ((p9 * wu * wu) <<< 37) + ((p10 * wu * wu * wt) <<< 21)
        + ((p11 * wu * wu * wu) <<< 20) + (160'sd1 <<< 78);
    if (acc < 0) begin
      r.pressure  = '0;
      r.saturated = 1'b1;
    end else if ((acc >>> 79) > 24'hFFFFFF) begin
      r.pressure  = 24'hFFFFFF;
      r.saturated = 1'b1;
    end else begin
      r.pressure = 24'(acc >>> 79);
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_beat_t want;
    if (result_valid) begin
      if (expected_readings.size() == 0) begin
        $error("result beat with no reading outstanding: %h", result);
        errors++;
      end else begin
        want = expected_readings.pop_front();
        if (result.temperature !== want.temperature) begin
          $error("temperature: expected %0d, got %0d",
                 $signed(want.temperature), $signed(result.temperature));
          errors++;
        end
        if (result.pressure !== want.pressure) begin
          $error("pressure: expected %0d, got %0d", want.pressure, result.pressure);
          errors++;
        end
        if (result.saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, result.saturated);
          errors++;
        end
      end
    end
    if (rst_ni && start && !busy) begin
      expected_readings.push_back(pin_gold ? pin_value : compensate(sample));
    end
    if (rst_ni && cfg_we) begin
      case (cfg_idx)
        CfgTempCal: mirror_temp_cal = cfg_wdata[TempCalW-1:0];
        CfgPressA:  mirror_press_a  = cfg_wdata;
        CfgPressB:  mirror_press_b  = cfg_wdata;
        default: ;
      endcase
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [RawW-1:0] corner_code();
    case ($urandom_range(0, 5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'h000001;
      3: return 24'h800000;
      4: return 24'h7FFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic in_beat_t next_sample();
    in_beat_t s;
    int kind;
    int level;
    kind = $urandom_range(0, 9);
    s.raw_pressure    = 24'($urandom);
    s.raw_temperature = 24'($urandom);
    if (kind < 6) begin
      level = 256 * int'(mirror_temp_cal[15:0]) + int'($urandom_range(0, 4194304)) - 2097152;
      if (level < 0) level = 0;
      if (level > 16777215) level = 16777215;
      s.raw_temperature = 24'(level);
      s.raw_pressure    = 24'($urandom_range(24'h300000, 24'hD00000));
    end else if (kind < 8) begin
      s.raw_pressure    = corner_code();
      s.raw_temperature = corner_code();
    end
    return s;
  endfunction

  task automatic drain();
    int waited;
    start  <= 1'b0;
    waited = 0;
    while (expected_readings.size() != 0 && waited < 4 * Latency) begin
      @(negedge clk_i);
      waited++;
    end
    if (expected_readings.size() != 0) begin
      $error("%0d readings never returned", expected_readings.size());
      errors++;
      expected_readings.delete();
    end
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
  endtask

  task automatic send_beat(in_beat_t smp, bit pinned, out_beat_t gold);
    int gap;
    start     <= 1'b1;
    sample    <= smp;
    pin_gold  <= pinned;
    pin_value <= gold;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  initial begin
    logic [CfgW-1:0] tc, pa, pb;
    rst_ni    = 1'b0;
    start     = 1'b0;
    sample    = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CfgTempCal;
    cfg_wdata = '0;
    pin_gold  = 1'b0;
    pin_value = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == RowWrite) begin
        if (!cfg_we) drain();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        cfg_we <= 1'b0;
        send_beat(directed_rows[i].beat, directed_rows[i].pinned, directed_rows[i].gold);
      end
    end

    for (int ph = 0; ph < PhaseCount; ph++) begin
      drain();
      if (ph == 0) begin
        tc = '0;
        pa = '0;
        pb = '0;
      end else if (ph == 1) begin
        tc = '1;
        pa = '1;
        pb = '1;
      end else if (ph >= PhaseCount - 2) begin
        tc = {$urandom, $urandom};
        pa = {$urandom, $urandom};
        pb = {$urandom, $urandom};
      end else begin
        tc = {24'($urandom), 8'($urandom), 16'($urandom_range(15000, 28000)),
              16'($urandom_range(20000, 30000))};
        pa = {16'($urandom_range(15000, 30000)), 8'($urandom), 8'($urandom),
              16'(int'($urandom_range(0, 8000)) - 4000),
              16'(int'($urandom_range(0, 8000)) - 4000)};
        pb = {$urandom, 16'($urandom), 16'($urandom_range(15000, 30000))};
      end
      if ($urandom_range(0, 1)) write_reg(CfgSpare, {$urandom, $urandom});
      write_reg(CfgTempCal, tc);
      write_reg(CfgPressA, pa);
      write_reg(CfgPressB, pb);
      cfg_we <= 1'b0;
      repeat (PhaseBeats) send_beat(next_sample(), 1'b0, '0);
    end

    drain();
    repeat (Latency + 4) @(negedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ barometer_pressure_temp_compensation.f @@
+incdir+hdl
hdl/bpc_pkg.sv
hdl/bpc_temp.sv
hdl/bpc_press_terms.sv
hdl/bpc_press_sum.sv
hdl/barometer_pressure_temp_compensation.sv
hdl/bpc_checker.sv
tb/sv/tb_barometer_pressure_temp_compensation.sv
